FILE: src/owm_pkg.sv
package owm_pkg;

   // Default width of the tick timer
   localparam int unsigned TIMER_BITS_DEF = 10;

   // Configuration registers
   localparam int unsigned CFG_W     = 10;
   localparam int unsigned NUM_CFG   = 8;
   localparam int unsigned CFG_SEL_W = 3;
   localparam int unsigned CFG_IDX_W = 4;

   typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_bank_type;

   typedef enum logic [CFG_SEL_W-1:0] {
      REG_RESET_TIME         = 3'd0,
      REG_PRESENCE_WAIT      = 3'd1,
      REG_SHORT_LOW          = 3'd2,
      REG_WRITE_ONE_RELEASE  = 3'd3,
      REG_WRITE_ZERO_LOW     = 3'd4,
      REG_WRITE_ZERO_RELEASE = 3'd5,
      REG_READ_SAMPLE_WAIT   = 3'd6,
      REG_READ_RELEASE       = 3'd7
   } cfg_sel_type;

   // Power-on register values, index 7 in the top slot
   localparam cfg_bank_type CFG_RESET = {
      10'd55, 10'd9, 10'd10, 10'd60, 10'd64, 10'd6, 10'd15, 10'd480
   };

   // Command codes on the mode field
   typedef enum logic [1:0] {
      MODE_RESET = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // Bus sequencer phases
   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_RST_LOW   = 7'b0000010,
      PH_RST_WAIT  = 7'b0000100,
      PH_RST_REC   = 7'b0001000,
      PH_SLOT_LOW  = 7'b0010000,
      PH_SLOT_REL  = 7'b0100000,
      PH_READ_TAIL = 7'b1000000
   } phase_type;

   // What the phase length lookup needs to know about the current slot
   typedef struct packed {
      phase_type phase;
      logic      read_cmd;
      logic      bit_one;
   } len_sel_type;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BIT_W  = 3;

endpackage

FILE: src/owm_phase_len.sv
module owm_phase_len #(
   parameter int unsigned TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  owm_pkg::len_sel_type  sel,
   input  owm_pkg::cfg_bank_type cfg,
   output logic [owm_pkg::CFG_W-1:0] len
);
   import owm_pkg::*;

   // Longest phase the timer can count
   localparam logic [CFG_W-1:0] LEN_MAX =
      (TIMER_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((1 << TIMER_BITS) - 1);

   cfg_sel_type      reg_sel;
   logic [CFG_W-1:0] raw;

   always_comb begin
      reg_sel = REG_RESET_TIME;
      unique case (sel.phase)
         PH_RST_LOW, PH_RST_REC: reg_sel = REG_RESET_TIME;
         PH_RST_WAIT:            reg_sel = REG_PRESENCE_WAIT;
         PH_SLOT_LOW:
            reg_sel = (sel.read_cmd || sel.bit_one) ? REG_SHORT_LOW : REG_WRITE_ZERO_LOW;
         PH_SLOT_REL:
            if (sel.read_cmd) begin
               reg_sel = REG_READ_SAMPLE_WAIT;
            end else begin
               reg_sel = sel.bit_one ? REG_WRITE_ONE_RELEASE : REG_WRITE_ZERO_RELEASE;
            end
         PH_READ_TAIL:           reg_sel = REG_READ_RELEASE;
         default:                reg_sel = REG_RESET_TIME;
      endcase
   end

   assign raw = cfg[reg_sel];

   // Zero counts as one tick; clamp to what the timer can reach
   always_comb begin
      if (raw == '0) begin
         len = CFG_W'(1);
      end else if (raw > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = raw;
      end
   end

endmodule

FILE: src/onewire_master_byte_engine.sv
// Single-wire bus master, one tick per input beat.
// An accepted req beat gets its rsp beat in the next cycle (one result register).
// Throughput: 1 beat per cycle unless rsp_stall holds the result register; the
// sequencer update is one pass of timer compare and phase decode (state to rsp regs).
// Reset (synchronous, active high): sequencer idle, timer/shift/flags cleared,
// registers back to power-on timing (480/15/6/64/60/10/9/55), rsp channel empty.
module onewire_master_byte_engine #(
   parameter int unsigned TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_start_req,
   input  logic [1:0]                    req_mode,
   input  logic [owm_pkg::BYTE_W-1:0]    req_write_value,
   input  logic                          req_bus_level,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drive_low,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [owm_pkg::BYTE_W-1:0]    rsp_read_value,
   output logic                          rsp_present,
   // register write port
   input  logic                          csr_wr_en,
   input  logic [owm_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [owm_pkg::CFG_W-1:0]     csr_wr_data
);
   import owm_pkg::*;

   // Compare width covers both the timer and the register range
   localparam int unsigned CMP_W = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;

   // ---------------------------------------------------------------------
   // Timing registers
   // ---------------------------------------------------------------------
   cfg_bank_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en && (csr_index < CFG_IDX_W'(NUM_CFG))) begin
         cfg_ff[csr_index[CFG_SEL_W-1:0]] <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   phase_type              phase_ff,    phase_in;
   logic [TIMER_BITS-1:0]  tick_timer_ff, tick_timer_in;
   logic [BIT_W-1:0]       bit_index_ff, bit_index_in;
   logic [BYTE_W-1:0]      shift_byte_ff, shift_byte_in;
   logic [1:0]             command_kind_ff, command_kind_in;
   logic                   presence_ff, presence_in;
   logic [BYTE_W-1:0]      last_read_ff, last_read_in;
   logic                   done;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   drive_low_ff, busy_ff, done_ff;

   logic                   req_beat;
   len_sel_type            len_sel;
   logic [CFG_W-1:0]       phase_len;
   logic                   phase_end;
   logic                   read_cmd;

   // Take a new tick whenever the result register is free or drains this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_beat  = req_valid && !req_stall;

   assign read_cmd         = (command_kind_ff == MODE_READ);
   assign len_sel.phase    = phase_ff;
   assign len_sel.read_cmd = read_cmd;
   assign len_sel.bit_one  = shift_byte_ff[0];

   owm_phase_len #(
      .TIMER_BITS (TIMER_BITS)
   ) u_phase_len (
      .sel (len_sel),
      .cfg (cfg_ff),
      .len (phase_len)
   );

   assign phase_end = (CMP_W'(tick_timer_ff) + CMP_W'(1)) >= CMP_W'(phase_len);

   // Next state for one tick
   always_comb begin
      phase_in        = phase_ff;
      tick_timer_in   = tick_timer_ff;
      bit_index_in    = bit_index_ff;
      shift_byte_in   = shift_byte_ff;
      command_kind_in = command_kind_ff;
      presence_in     = presence_ff;
      last_read_in    = last_read_ff;
      done            = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // Launch a command; mode three means nothing and is dropped
         if (req_start_req && (req_mode != MODE_NONE)) begin
            command_kind_in = req_mode;
            tick_timer_in   = '0;
            bit_index_in    = '0;
            if (req_mode == MODE_RESET) begin
               phase_in = PH_RST_LOW;
            end else begin
               shift_byte_in = (req_mode == MODE_WRITE) ? req_write_value : '0;
               phase_in      = PH_SLOT_LOW;
            end
         end
      end else if (phase_end) begin
         tick_timer_in = '0;
         unique case (phase_ff)
            PH_RST_LOW: phase_in = PH_RST_WAIT;
            PH_RST_WAIT: begin
               // Presence: a device holds the bus low
               presence_in = !req_bus_level;
               phase_in    = PH_RST_REC;
            end
            PH_RST_REC: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_SLOT_LOW: phase_in = PH_SLOT_REL;
            PH_SLOT_REL: begin
               if (read_cmd) begin
                  // Sample the read bit into the top, shift toward LSB
                  shift_byte_in = {req_bus_level, shift_byte_ff[BYTE_W-1:1]};
                  phase_in      = PH_READ_TAIL;
               end else begin
                  shift_byte_in = {1'b0, shift_byte_ff[BYTE_W-1:1]};
                  if (bit_index_ff == BIT_W'(BYTE_W - 1)) begin
                     bit_index_in = '0;
                     phase_in     = PH_IDLE;
                     done         = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + BIT_W'(1);
                     phase_in     = PH_SLOT_LOW;
                  end
               end
            end
            PH_READ_TAIL: begin
               if (bit_index_ff == BIT_W'(BYTE_W - 1)) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
                  last_read_in = shift_byte_ff;
               end else begin
                  bit_index_in = bit_index_ff + BIT_W'(1);
                  phase_in     = PH_SLOT_LOW;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end else begin
         tick_timer_in = tick_timer_ff + TIMER_BITS'(1);
      end
   end

   // Advance the sequencer only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_timer_ff   <= '0;
         bit_index_ff    <= '0;
         shift_byte_ff   <= '0;
         command_kind_ff <= '0;
         presence_ff     <= 1'b0;
         last_read_ff    <= '0;
      end else if (req_beat) begin
         phase_ff        <= phase_in;
         tick_timer_ff   <= tick_timer_in;
         bit_index_ff    <= bit_index_in;
         shift_byte_ff   <= shift_byte_in;
         command_kind_ff <= command_kind_in;
         presence_ff     <= presence_in;
         last_read_ff    <= last_read_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on every accepted tick, hold while stalled
   // ---------------------------------------------------------------------
   always_comb begin
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         drive_low_ff <= (phase_in == PH_RST_LOW) || (phase_in == PH_SLOT_LOW);
         busy_ff      <= (phase_in != PH_IDLE);
         done_ff      <= done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_low  = drive_low_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_done_res   = done_ff;
   // Read byte and presence are sequencer state already updated with the beat
   assign rsp_read_value = last_read_ff;
   assign rsp_present    = presence_ff;

`ifndef SYNTHESIS
   // The bus is only pulled low while a command runs
   a_drive_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_drive_low && !rsp_busy_res))
      else $error("drive_low without busy");

   // A completing command leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_res && rsp_busy_res))
      else $error("done while busy");

   // An empty result register never holds off the tick channel
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("stall with empty result register");

   // Bit counter only moves inside a byte transfer
   a_bit_index_in_slot: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff != '0) |-> ((phase_ff == PH_SLOT_LOW) || (phase_ff == PH_SLOT_REL)
                                || (phase_ff == PH_READ_TAIL)))
      else $error("bit index outside byte transfer");
`endif

endmodule

FILE: dv/onewire_master_byte_engine_tb.sv
// Bench for the single-wire bus master byte engine.
// Every req beat is one timing tick and returns exactly one rsp beat, so the
// tracker below advances its own copy of the sequencer on each accepted tick
// and queues the outputs that tick must produce. The run steps through several
// timing settings: a directed pass with the shortest slots, random stretches
// with short slots, a zero-length pass, a longer-slot pass and a last short one.
module onewire_master_byte_engine_tb;
   import owm_pkg::*;

   // One tick as offered on the req channel
   typedef struct {
      logic                start;
      mode_type            mode;
      logic [BYTE_W-1:0]   wval;
      logic                bus;
   } tick_type;

   // What the block shows on the rsp channel for one tick
   typedef struct {
      logic                drive_low;
      logic                busy;
      logic                done;
      logic [BYTE_W-1:0]   read_value;
      logic                present;
   } bus_view_type;

   typedef logic [CFG_W-1:0] timing_set_type [NUM_CFG];

   // Tracks the sequencer tick by tick and holds the outputs still owed.
   class bus_master_tracker;
      logic [CFG_W-1:0]            timing [NUM_CFG];
      phase_type                   seq_phase;
      logic [TIMER_BITS_DEF-1:0]   timer;
      logic [BIT_W-1:0]            bit_idx;
      logic [BYTE_W-1:0]           shifter;
      mode_type                    kind;
      logic                        presence;
      logic [BYTE_W-1:0]           last_read;
      bus_view_type                expected_outputs [$];
      int unsigned                 mismatches;
      int unsigned                 completed;
      int unsigned                 resets_run;
      int unsigned                 writes_run;
      int unsigned                 reads_run;
      int unsigned                 ticks_seen;

      function new();
         foreach (timing[i]) timing[i] = CFG_RESET[i];
         seq_phase  = PH_IDLE;
         timer      = '0;
         bit_idx    = '0;
         shifter    = '0;
         kind       = MODE_RESET;
         presence   = 1'b0;
         last_read  = '0;
         mismatches = 0;
         completed  = 0;
         resets_run = 0;
         writes_run = 0;
         reads_run  = 0;
         ticks_seen = 0;
      endfunction

      function bit busy();
         return seq_phase != PH_IDLE;
      endfunction

      // Indexes past the last register fall on nothing
      function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx < NUM_CFG) timing[idx[CFG_SEL_W-1:0]] = val;
      endfunction

      // Zero counts as one tick; anything past the timer clamps to its top
      function int unsigned span(cfg_sel_type r);
         int unsigned d;
         d = 32'(timing[r]);
         if (d == 0) d = 1;
         if (d > (1 << TIMER_BITS_DEF) - 1) d = (1 << TIMER_BITS_DEF) - 1;
         return d;
      endfunction

      function int unsigned phase_span();
         case (seq_phase)
            PH_RST_LOW, PH_RST_REC: return span(REG_RESET_TIME);
            PH_RST_WAIT: return span(REG_PRESENCE_WAIT);
            PH_SLOT_LOW: begin
               if (kind == MODE_READ || shifter[0]) return span(REG_SHORT_LOW);
               return span(REG_WRITE_ZERO_LOW);
            end
            PH_SLOT_REL: begin
               if (kind == MODE_READ) return span(REG_READ_SAMPLE_WAIT);
               if (shifter[0]) return span(REG_WRITE_ONE_RELEASE);
               return span(REG_WRITE_ZERO_RELEASE);
            end
            PH_READ_TAIL: return span(REG_READ_RELEASE);
            default: return 1;
         endcase
      endfunction

      // Move to the next slot, or finish after the eighth
      function bit close_slot();
         if (&bit_idx) begin
            bit_idx   = '0;
            seq_phase = PH_IDLE;
            return 1'b1;
         end
         bit_idx++;
         seq_phase = PH_SLOT_LOW;
         return 1'b0;
      endfunction

      function void note_tick(tick_type t);
         bus_view_type want;
         bit           done;
         done = 1'b0;
         ticks_seen++;
         if (seq_phase == PH_IDLE) begin
            // a command starts on the tick it shows up; mode three does nothing
            if (t.start && t.mode != MODE_NONE) begin
               kind    = t.mode;
               timer   = '0;
               bit_idx = '0;
               case (t.mode)
                  MODE_RESET: begin
                     seq_phase = PH_RST_LOW;
                     resets_run++;
                  end
                  MODE_WRITE: begin
                     shifter   = t.wval;
                     seq_phase = PH_SLOT_LOW;
                     writes_run++;
                  end
                  default: begin
                     shifter   = '0;
                     seq_phase = PH_SLOT_LOW;
                     reads_run++;
                  end
               endcase
            end
         end else if (int'(timer) + 1 >= phase_span()) begin
            timer = '0;
            case (seq_phase)
               PH_RST_LOW: seq_phase = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  // a device answers by holding the line low
                  presence  = ~t.bus;
                  seq_phase = PH_RST_REC;
               end
               PH_RST_REC: begin
                  seq_phase = PH_IDLE;
                  done      = 1'b1;
               end
               PH_SLOT_LOW: seq_phase = PH_SLOT_REL;
               PH_SLOT_REL: begin
                  if (kind == MODE_READ) begin
                     shifter   = {t.bus, shifter[BYTE_W-1:1]};
                     seq_phase = PH_READ_TAIL;
                  end else begin
                     shifter = shifter >> 1;
                     done    = close_slot();
                  end
               end
               PH_READ_TAIL: begin
                  done = close_slot();
                  if (done) last_read = shifter;
               end
               default: seq_phase = PH_IDLE;
            endcase
         end else begin
            timer++;
         end
         if (done) completed++;
         want.drive_low  = (seq_phase == PH_RST_LOW || seq_phase == PH_SLOT_LOW);
         want.busy       = (seq_phase != PH_IDLE);
         want.done       = done;
         want.read_value = last_read;
         want.present    = presence;
         expected_outputs.push_back(want);
      endfunction

      function void compare_field(string name, logic [BYTE_W-1:0] want,
                                  logic [BYTE_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(bus_view_type got);
         bus_view_type want;
         if (expected_outputs.size() == 0) begin
            $display("%0t: rsp beat with no tick outstanding", $time);
            mismatches++;
            return;
         end
         want = expected_outputs.pop_front();
         compare_field("drive_low", BYTE_W'(want.drive_low), BYTE_W'(got.drive_low));
         compare_field("busy_res", BYTE_W'(want.busy), BYTE_W'(got.busy));
         compare_field("done_res", BYTE_W'(want.done), BYTE_W'(got.done));
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("present", BYTE_W'(want.present), BYTE_W'(got.present));
      endfunction
   endclass

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // Block inputs, all known from time zero
   logic                  req_valid       = 1'b0;
   logic                  req_start_req   = 1'b0;
   logic [1:0]            req_mode        = MODE_RESET;
   logic [BYTE_W-1:0]     req_write_value = '0;
   logic                  req_bus_level   = 1'b1;
   logic                  rsp_stall       = 1'b0;
   logic                  csr_wr_en       = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index       = '0;
   logic [CFG_W-1:0]      csr_wr_data     = '0;

   // Block outputs
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_drive_low;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [BYTE_W-1:0]     rsp_read_value;
   logic                  rsp_present;

   onewire_master_byte_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_req   (req_start_req),
      .req_mode        (req_mode),
      .req_write_value (req_write_value),
      .req_bus_level   (req_bus_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive_low   (rsp_drive_low),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_value  (rsp_read_value),
      .rsp_present     (rsp_present),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   bus_master_tracker tracker = new();

   int unsigned ticks_offered = 0;
   int unsigned settings_used = 0;
   int unsigned rx_cycle      = 0;
   int unsigned hold_left     = 0;
   bit          squeeze_req   = 1'b0;

   // Receiver: stall at random about 15% of the time. Keep a quiet window with
   // no stalls, and on request hold off for a long stretch so the block backs
   // up and pushes stall onto the req side while beats keep coming.
   always @(posedge clock) begin
      rx_cycle++;
      if (squeeze_req && hold_left == 0) begin
         hold_left   = 400;
         squeeze_req = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_cycle >= 1000 && rx_cycle < 1800) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 15);
      end
   end

   // Check every rsp beat taken at this edge against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result('{rsp_drive_low, rsp_busy_res, rsp_done_res,
                                rsp_read_value, rsp_present});
   end

   // Offer one tick and hold it until accepted. Insert random idle cycles in
   // front of it, except in a quiet window of back-to-back beats.
   task automatic send_tick(tick_type t);
      while (!(ticks_offered >= 300 && ticks_offered < 700) &&
             $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_req   <= t.start;
      req_mode        <= t.mode;
      req_write_value <= t.wval;
      req_bus_level   <= t.bus;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(t);
      ticks_offered++;
   endtask

   // While busy, throw commands at the block half the time; they must drop.
   function automatic tick_type random_tick();
      tick_type t;
      t.start = tracker.busy() ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 40);
      t.mode  = ($urandom_range(0, 99) < 8) ? MODE_NONE :
                mode_type'($urandom_range(MODE_RESET, MODE_READ));
      t.wval  = BYTE_W'($urandom);
      t.bus   = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // Launch one command, then keep start high with a fixed bus level until it
   // completes, so commands while busy and on the done tick are both seen.
   task automatic run_command(mode_type m, logic [BYTE_W-1:0] v, logic bus);
      tick_type t;
      t = '{1'b1, m, v, bus};
      send_tick(t);
      while (tracker.busy()) begin
         t = '{1'b1, mode_type'($urandom_range(MODE_RESET, MODE_READ)),
               BYTE_W'($urandom), bus};
         send_tick(t);
      end
   endtask

   // Random ticks, then more until the sequencer is back to idle
   task automatic run_random(int unsigned n);
      repeat (n) send_tick(random_tick());
      while (tracker.busy()) send_tick(random_tick());
   endtask

   // Drop valid and let every owed rsp beat drain, plus the result register.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_outputs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Reprogram all timing registers with the block idle; optionally add one
   // write to an index past the last register, which must change nothing.
   task automatic retime(timing_set_type vals, bit stray);
      logic [CFG_IDX_W-1:0] stray_idx;
      logic [CFG_W-1:0]     stray_val;
      settle();
      for (int i = 0; i < NUM_CFG; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CFG_IDX_W'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
         tracker.write_reg(CFG_IDX_W'(i), vals[i]);
      end
      if (stray) begin
         stray_idx   = CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1));
         stray_val   = CFG_W'($urandom);
         csr_index   <= stray_idx;
         csr_wr_data <= stray_val;
         @(posedge clock);
         tracker.write_reg(stray_idx, stray_val);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic timing_set_type pick_timing(int unsigned lo, int unsigned hi);
      timing_set_type ts;
      foreach (ts[i]) ts[i] = CFG_W'($urandom_range(lo, hi));
      return ts;
   endfunction

   initial begin
      timing_set_type ts;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: shortest timing, presence both ways, all-zero and all-one
      // bytes, reads of both levels, mode three and an empty tick.
      ts = pick_timing(1, 1);
      retime(ts, 1'b0);
      run_command(MODE_RESET, 8'h00, 1'b0);
      run_command(MODE_RESET, 8'h00, 1'b1);
      run_command(MODE_WRITE, 8'hFF, 1'b1);
      run_command(MODE_WRITE, 8'h00, 1'b0);
      run_command(MODE_READ, 8'h00, 1'b1);
      run_command(MODE_READ, 8'hA5, 1'b0);
      run_command(MODE_NONE, 8'h5A, 1'b1);
      send_tick('{1'b0, MODE_READ, 8'h00, 1'b0});

      // Short random timing; hold the receiver off early on
      ts = pick_timing(1, 4);
      retime(ts, 1'b1);
      squeeze_req = 1'b1;
      run_random(400);

      // Zero-length registers mixed in
      ts = pick_timing(0, 2);
      retime(ts, 1'b0);
      run_random(300);

      ts = pick_timing(1, 12);
      retime(ts, 1'b1);
      run_random(200);

      ts = pick_timing(1, 3);
      retime(ts, 1'b1);
      run_random(200);

      settle();
      $display("Ran %0d ticks across %0d timing settings; %0d commands completed",
               tracker.ticks_seen, settings_used, tracker.completed);
      $display("Started %0d resets, %0d byte writes, %0d byte reads; %0d mismatches",
               tracker.resets_run, tracker.writes_run, tracker.reads_run,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #200000;
      $display("Timed out with %0d rsp beats outstanding",
               tracker.expected_outputs.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
src/owm_pkg.sv
src/owm_phase_len.sv
src/onewire_master_byte_engine.sv
dv/onewire_master_byte_engine_tb.sv
